// File: design/atsw_pkg.sv
package atsw_pkg;

  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_TEXT_ROWS = 24;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic FUNC_READ = 1'b1;

  localparam logic [8:0] CHAR_LF    = 9'd10;
  localparam logic [8:0] CHAR_ESC   = 9'd27;
  localparam logic [8:0] CHAR_SEMI  = 9'd59;
  localparam logic [8:0] CHAR_LBRKT = 9'd91;
  localparam logic [8:0] CHAR_M     = 9'd109;
  localparam logic [8:0] CHAR_BS    = 9'd256;

  localparam logic [7:0]  DIGIT_ZERO   = 8'd48;
  localparam logic [11:0] NO_VALUE     = 12'hFFF;
  localparam logic [15:0] ATTR_NORMAL  = 16'h0700;
  localparam logic [15:0] ATTR_MAGENTA = 16'h0500;
  localparam logic [15:0] CELL_BLANK   = 16'h0720;

  localparam logic [15:0] FG_COLOUR [10] = '{
    16'h0000, 16'h0400, 16'h0200, 16'h0600, 16'h0100,
    16'h0500, 16'h0300, 16'h0700, 16'h0700, 16'h0700
  };
  localparam logic [15:0] BG_COLOUR [10] = '{
    16'h0000, 16'h4000, 16'h2000, 16'h6000, 16'h1000,
    16'h5000, 16'h3000, 16'h7000, 16'h0000, 16'h0000
  };

  typedef enum logic [2:0] {
    OP_READ,
    OP_DRAW,
    OP_NEWLINE,
    OP_BACK,
    OP_STAY
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] glyph;
    logic [10:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [15:0] attr;
    logic        stop;
  } colour_t;

  // two digit slots read as a c string, wrapped to 12 bits
  function automatic logic [11:0] slot_value(input logic [7:0] s0, input logic [7:0] s1);
    logic [11:0] a;
    logic [11:0] v;
    a = {4'b0, s0} - {4'b0, DIGIT_ZERO};
    v = '0;
    if (s0 != 8'd0) begin
      v = a;
      if (s1 != 8'd0) begin
        v = (a << 3) + (a << 1) + {4'b0, s1} - {4'b0, DIGIT_ZERO};
      end
    end
    return v;
  endfunction

  function automatic colour_t colour_of(input logic [11:0] v);
    colour_t c;
    c.attr = '0;
    c.stop = 1'b0;
    if (v inside {[12'd40:12'd49]}) begin
      c.attr = BG_COLOUR[4'(v - 12'd40)];
    end else if (v inside {[12'd30:12'd39]}) begin
      c.attr = FG_COLOUR[4'(v - 12'd30)];
    end else if (v == 12'd0) begin
      c.attr = ATTR_NORMAL;
      c.stop = 1'b1;
    end else if (v == NO_VALUE) begin
      c.attr = ATTR_MAGENTA;
    end
    return c;
  endfunction

endpackage

// File: design/atsw_in_if.sv
interface atsw_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [8:0]  char_code;
  logic [10:0] cell_address;

  modport source (output valid, func, char_code, cell_address, input ready);
  modport sink (input valid, func, char_code, cell_address, output ready);
endinterface

// File: design/atsw_out_if.sv
interface atsw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_data;
  logic [10:0] cursor_position;

  modport source (output valid, cell_data, cursor_position, input ready);
  modport sink (input valid, cell_data, cursor_position, output ready);
endinterface

// File: design/atsw_front.sv
module atsw_front (
  input  logic            clk,
  input  logic            rst_n,
  atsw_in_if.sink         in_ch,
  input  logic            init_done,
  input  logic            q_ready,
  output logic            q_push,
  output atsw_pkg::cmd_t  q_cmd
);

  logic        escape_r, escape_nxt;
  logic        reading_r, reading_nxt;
  logic        style_r, style_nxt;
  logic [7:0]  slot0_r, slot0_nxt;
  logic [7:0]  slot1_r, slot1_nxt;
  logic [1:0]  dcount_r, dcount_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic [11:0] pv0_r, pv0_nxt;
  logic [11:0] pv1_r, pv1_nxt;

  logic [11:0]        sval;
  atsw_pkg::colour_t  col0;
  atsw_pkg::colour_t  col1;
  logic               two_vals;
  logic [8:0]         c;
  logic               accept;

  assign in_ch.ready = q_ready && init_done;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  assign sval     = atsw_pkg::slot_value(slot0_r, slot1_r);
  assign col0     = atsw_pkg::colour_of(pv0_r);
  assign col1     = atsw_pkg::colour_of(pv1_r);
  assign two_vals = pv1_r != atsw_pkg::NO_VALUE;
  assign c        = in_ch.char_code;

  always_comb begin
    escape_nxt  = escape_r;
    reading_nxt = reading_r;
    style_nxt   = style_r;
    slot0_nxt   = slot0_r;
    slot1_nxt   = slot1_r;
    dcount_nxt  = dcount_r;
    pidx_nxt    = pidx_r;
    pv0_nxt     = pv0_r;
    pv1_nxt     = pv1_r;
    q_cmd.op    = atsw_pkg::OP_STAY;
    q_cmd.glyph = '0;
    q_cmd.addr  = in_ch.cell_address;

    if (in_ch.func == atsw_pkg::FUNC_READ) begin
      q_cmd.op = atsw_pkg::OP_READ;
    end else begin
      if (c == atsw_pkg::CHAR_ESC) begin
        escape_nxt  = 1'b1;
        reading_nxt = 1'b0;
        style_nxt   = 1'b0;
      end
      if (c == atsw_pkg::CHAR_LF) begin
        q_cmd.op = atsw_pkg::OP_NEWLINE;
      end else if (c == atsw_pkg::CHAR_BS) begin
        q_cmd.op = atsw_pkg::OP_BACK;
      end else if (c == atsw_pkg::CHAR_ESC || (escape_r && c == atsw_pkg::CHAR_LBRKT)) begin
        reading_nxt = 1'b1;
        dcount_nxt  = '0;
        pidx_nxt    = '0;
        slot0_nxt   = atsw_pkg::DIGIT_ZERO;
        slot1_nxt   = atsw_pkg::DIGIT_ZERO;
        pv0_nxt     = atsw_pkg::NO_VALUE;
        pv1_nxt     = atsw_pkg::NO_VALUE;
      end else if (escape_r && c == atsw_pkg::CHAR_M) begin
        style_nxt   = 1'b1;
        escape_nxt  = 1'b0;
        reading_nxt = 1'b0;
        if (pidx_r == 2'd0) begin
          pv0_nxt = sval;
        end else if (pidx_r == 2'd1) begin
          pv1_nxt = sval;
        end
        pidx_nxt = '0;
      end else if (reading_r) begin
        if (c == atsw_pkg::CHAR_SEMI) begin
          if (pidx_r == 2'd0) begin
            pv0_nxt  = sval;
            pidx_nxt = 2'd1;
          end else if (pidx_r == 2'd1) begin
            pv1_nxt  = sval;
            pidx_nxt = 2'd2;
          end
          slot0_nxt  = atsw_pkg::DIGIT_ZERO;
          slot1_nxt  = atsw_pkg::DIGIT_ZERO;
          dcount_nxt = '0;
        end else if (dcount_r < 2'd2) begin
          if (dcount_r == 2'd0) begin
            slot0_nxt = c[7:0];
          end else begin
            slot1_nxt = c[7:0];
          end
          dcount_nxt = dcount_r + 2'd1;
        end
      end else if (style_r) begin
        q_cmd.op    = atsw_pkg::OP_DRAW;
        q_cmd.glyph = {8'h00, c[7:0]} | col0.attr
                    | ((two_vals && !col0.stop) ? col1.attr : 16'h0000);
        // a zero value ends the style and drops both values
        if (col0.stop || (two_vals && col1.stop)) begin
          pv0_nxt     = atsw_pkg::NO_VALUE;
          pv1_nxt     = atsw_pkg::NO_VALUE;
          reading_nxt = 1'b0;
          style_nxt   = 1'b0;
        end
      end else begin
        q_cmd.op    = atsw_pkg::OP_DRAW;
        q_cmd.glyph = {8'h00, c[7:0]} | atsw_pkg::ATTR_NORMAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r  <= 1'b0;
      reading_r <= 1'b0;
      style_r   <= 1'b0;
      slot0_r   <= '0;
      slot1_r   <= '0;
      dcount_r  <= '0;
      pidx_r    <= '0;
      pv0_r     <= atsw_pkg::NO_VALUE;
      pv1_r     <= atsw_pkg::NO_VALUE;
    end else if (accept) begin
      escape_r  <= escape_nxt;
      reading_r <= reading_nxt;
      style_r   <= style_nxt;
      slot0_r   <= slot0_nxt;
      slot1_r   <= slot1_nxt;
      dcount_r  <= dcount_nxt;
      pidx_r    <= pidx_nxt;
      pv0_r     <= pv0_nxt;
      pv1_r     <= pv1_nxt;
    end
  end

endmodule

// File: design/atsw_queue.sv
module atsw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  atsw_pkg::cmd_t  push_cmd,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output atsw_pkg::cmd_t  head
);

  localparam int DEPTH = atsw_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  atsw_pkg::cmd_t entries_r [DEPTH];
  logic [AW-1:0]  wptr_r, wptr_nxt;
  logic [AW-1:0]  rptr_r, rptr_nxt;
  logic [AW:0]    count_r, count_nxt;

  assign ready = count_r != (AW+1)'(DEPTH);
  assign valid = count_r != '0;
  assign head  = entries_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + AW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + AW'(1) : rptr_r;
    count_nxt = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/atsw_back.sv
module atsw_back #(
  parameter int COLUMNS   = atsw_pkg::DEF_COLUMNS,
  parameter int TEXT_ROWS = atsw_pkg::DEF_TEXT_ROWS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  atsw_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            init_done,
  atsw_out_if.source      out_ch
);

  localparam int TEXT_CELLS = COLUMNS * TEXT_ROWS;
  localparam int MOVE_CELLS = TEXT_CELLS - COLUMNS;
  localparam int CW         = $clog2(TEXT_CELLS);
  localparam int COLW       = $clog2(COLUMNS);
  localparam int ROWW       = $clog2(TEXT_ROWS);

  localparam logic [CW-1:0]   LAST_CELL     = CW'(TEXT_CELLS - 1);
  localparam logic [CW-1:0]   LAST_ROW_BASE = CW'(MOVE_CELLS);
  localparam logic [CW-1:0]   ROW_STRIDE    = CW'(COLUMNS);
  localparam logic [COLW-1:0] LAST_COL      = COLW'(COLUMNS - 1);
  localparam logic [ROWW-1:0] LAST_ROW      = ROWW'(TEXT_ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BLANK,
    S_READ,
    S_COPY,
    S_ZERO,
    S_EMIT
  } state_t;

  logic [15:0] mem [TEXT_CELLS];
  logic [15:0] rdata_r;
  logic        mem_we;
  logic [CW-1:0] mem_waddr;
  logic [CW-1:0] mem_raddr;
  logic [15:0]   mem_wdata;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [ROWW-1:0] row_r, row_nxt;
  logic          hit_r, hit_nxt;
  logic [15:0]   res_data_r, res_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_data_r, out_data_nxt;
  logic [10:0]   out_cursor_r, out_cursor_nxt;
  logic          out_free;

  assign init_done              = state_r != S_CLEAR;
  assign out_free               = !out_valid_r || out_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.cell_data       = out_data_r;
  assign out_ch.cursor_position = out_cursor_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    hit_nxt        = hit_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_cursor_nxt = out_cursor_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cursor_r;
    mem_wdata      = atsw_pkg::CELL_BLANK;
    mem_raddr      = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          res_data_nxt = '0;
          state_nxt    = S_BLANK;
          case (q_cmd.op)
            atsw_pkg::OP_READ: begin
              mem_raddr = CW'(q_cmd.addr);
              hit_nxt   = 32'(q_cmd.addr) < 32'(TEXT_CELLS);
              state_nxt = S_READ;
            end
            atsw_pkg::OP_DRAW: begin
              mem_we    = 1'b1;
              mem_waddr = cursor_r;
              mem_wdata = q_cmd.glyph;
              if (col_r == LAST_COL) begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  cursor_nxt = LAST_ROW_BASE;
                  cnt_nxt    = '0;
                  state_nxt  = S_COPY;
                end else begin
                  row_nxt    = row_r + ROWW'(1);
                  cursor_nxt = cursor_r + CW'(1);
                end
              end else begin
                col_nxt    = col_r + COLW'(1);
                cursor_nxt = cursor_r + CW'(1);
              end
            end
            atsw_pkg::OP_NEWLINE: begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                cursor_nxt = LAST_ROW_BASE;
                cnt_nxt    = '0;
                state_nxt  = S_COPY;
              end else begin
                row_nxt    = row_r + ROWW'(1);
                cursor_nxt = cursor_r - CW'(col_r) + ROW_STRIDE;
              end
            end
            atsw_pkg::OP_BACK: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - CW'(1);
                if (col_r == '0) begin
                  col_nxt = LAST_COL;
                  row_nxt = row_r - ROWW'(1);
                end else begin
                  col_nxt = col_r - COLW'(1);
                end
              end
            end
            default: begin
              state_nxt = S_BLANK;
            end
          endcase
        end
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_r;
        mem_wdata = atsw_pkg::CELL_BLANK;
        state_nxt = S_EMIT;
      end
      S_READ: begin
        res_data_nxt = hit_r ? rdata_r : 16'h0000;
        state_nxt    = S_EMIT;
      end
      S_COPY: begin
        // read one row down, write the cell fetched in the cycle before
        if (cnt_r != LAST_ROW_BASE) begin
          mem_raddr = cnt_r + ROW_STRIDE;
        end
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - CW'(1);
          mem_wdata = rdata_r;
        end
        if (cnt_r == LAST_ROW_BASE) begin
          state_nxt = S_ZERO;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_ZERO: begin
        // last text row cleared, blank under the cursor at its start
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = (cnt_r == LAST_ROW_BASE) ? atsw_pkg::CELL_BLANK : 16'h0000;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_cursor_nxt = 11'(cursor_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cursor_r     <= cursor_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
      hit_r        <= hit_nxt;
      res_data_r   <= res_data_nxt;
      out_data_r   <= out_data_nxt;
      out_cursor_r <= out_cursor_nxt;
    end
  end

endmodule

// File: design/ansi_text_screen_writer.sv
// text screen writer with ansi sgr colour sequences
// in_ch carries one transaction per byte or read request: func 0 writes char_code
//   (256 is backspace), func 1 reads back the cell at cell_address
// out_ch returns one transaction per input: cell_data (0 on writes) and the cursor
// the front end parses escape sequences and pushes commands into a four-entry
//   queue, the back end owns the cursor and the cell memory (one read, one write a cycle)
// an ordinary item passes through the back-end states in order: S_IDLE writes the character,
//   S_BLANK writes the blank under the cursor, S_EMIT loads the output register
// out_ch.valid comes from the output register, loaded in S_EMIT when the back end is free
// a scroll copies the text rows up through the memory port, one cell a cycle,
//   then clears the last row
// after reset the back end sweeps all COLUMNS * TEXT_ROWS cells to zero
//   with in_ch.ready held low
// the row below the text rows is never written and always reads as zero
// if the receiver stalls, the result stays in the output register and the
//   queue keeps taking input until it fills
module ansi_text_screen_writer #(
  parameter int COLUMNS   = atsw_pkg::DEF_COLUMNS,
  parameter int TEXT_ROWS = atsw_pkg::DEF_TEXT_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  atsw_in_if.sink     in_ch,
  atsw_out_if.source  out_ch
);

  logic            init_done;
  logic            q_push;
  logic            q_ready;
  logic            q_pop;
  logic            q_valid;
  atsw_pkg::cmd_t  push_cmd;
  atsw_pkg::cmd_t  head_cmd;

  atsw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .init_done (init_done),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  atsw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  atsw_back #(
    .COLUMNS   (COLUMNS),
    .TEXT_ROWS (TEXT_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> init_done)
    else $error("transaction accepted during the clearing sweep");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.cursor_position) < 32'(COLUMNS * TEXT_ROWS)))
    else $error("cursor outside the text rows");
`endif

endmodule

// File: sim/screen_result_checker.sv
`timescale 1ns / 1ps

module screen_result_checker (
  input  logic clk,
  input  logic rst_n,
  atsw_in_if   in_mon,
  atsw_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_results,
  output int   results_checked,
  output int   scroll_count,
  output int   styled_draws
);
  import atsw_pkg::*;

  localparam int COLS       = DEF_COLUMNS;
  localparam int ROWS       = DEF_TEXT_ROWS;
  localparam int TEXT_CELLS = COLS * ROWS;
  localparam int ALL_CELLS  = COLS * (ROWS + 1);

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] cursor;
  } screen_result_t;

  screen_result_t expected_results[$];
  screen_result_t want;

  // shadow copy of the display and the escape parser
  logic [15:0] screen [ALL_CELLS];
  int          cursor;
  bit          esc_seen;
  bit          in_params;
  bit          styled;
  logic [7:0]  slot [2];
  int          digits;
  int          pidx;
  logic [11:0] pval [2];

  logic [15:0] read_data;
  int          errs;
  int          checked;
  int          scrolls;
  int          styled_total;

  // two digit slots read like a c string, wrapped to 12 bits
  function automatic logic [11:0] sgr_number(input logic [7:0] s0, input logic [7:0] s1);
    int v;
    v = 0;
    if (s0 != 8'd0) begin
      v = int'(s0) - 48;
      if (s1 != 8'd0) v = v * 10 + int'(s1) - 48;
    end
    return 12'(v);
  endfunction

  task automatic feed_char(input logic [8:0] c);
    logic [15:0] drawn;
    int          n;
    int          sv;
    if (c == CHAR_ESC) begin
      esc_seen  = 1'b1;
      in_params = 1'b0;
      styled    = 1'b0;
    end
    if (c == CHAR_LF) begin
      cursor = cursor + COLS - cursor % COLS;
    end else if (c == CHAR_BS) begin
      if (cursor > 0) cursor--;
    end else if (c == CHAR_ESC || (esc_seen && c == CHAR_LBRKT)) begin
      in_params = 1'b1;
      digits    = 0;
      pidx      = 0;
      slot[0]   = DIGIT_ZERO;
      slot[1]   = DIGIT_ZERO;
      pval[0]   = NO_VALUE;
      pval[1]   = NO_VALUE;
    end else if (esc_seen && c == CHAR_M) begin
      styled    = 1'b1;
      esc_seen  = 1'b0;
      in_params = 1'b0;
      if (pidx < 2) pval[pidx] = sgr_number(slot[0], slot[1]);
      pidx = 0;
    end else if (in_params) begin
      if (c == CHAR_SEMI) begin
        // a third value is dropped but still refills the slots
        if (pidx < 2) begin
          pval[pidx] = sgr_number(slot[0], slot[1]);
          pidx++;
        end
        slot[0] = DIGIT_ZERO;
        slot[1] = DIGIT_ZERO;
        digits  = 0;
      end else if (digits < 2) begin
        slot[digits] = c[7:0];
        digits++;
      end
    end else if (styled) begin
      drawn = {8'h00, c[7:0]};
      n = (pval[1] != NO_VALUE) ? 2 : 1;
      for (int i = 0; i < n; i++) begin
        sv = $signed(pval[i]);
        if (sv >= 40 && sv <= 49) begin
          drawn |= BG_COLOUR[sv - 40];
        end else if (sv >= 30 && sv <= 39) begin
          drawn |= FG_COLOUR[sv - 30];
        end else if (sv == 0) begin
          // reset value ends the style after this character
          drawn |= ATTR_NORMAL;
          pval[0]   = NO_VALUE;
          pval[1]   = NO_VALUE;
          in_params = 1'b0;
          styled    = 1'b0;
          break;
        end else if (sv == -1) begin
          drawn |= ATTR_MAGENTA;
        end
      end
      if (cursor < ALL_CELLS) screen[cursor] = drawn;
      cursor++;
      styled_total++;
    end else begin
      if (cursor < ALL_CELLS) screen[cursor] = {8'h00, c[7:0]} | ATTR_NORMAL;
      cursor++;
    end

    if (cursor / COLS >= ROWS) begin
      for (int k = 0; k < (ROWS - 1) * COLS; k++) screen[k] = screen[k + COLS];
      cursor -= COLS;
      for (int k = cursor; k < TEXT_CELLS; k++) screen[k] = '0;
      scrolls++;
    end
    if (cursor < ALL_CELLS) screen[cursor] = CELL_BLANK;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ALL_CELLS; k++) screen[k] = '0;
      cursor       = 0;
      esc_seen     = 1'b0;
      in_params    = 1'b0;
      styled       = 1'b0;
      slot[0]      = 8'd0;
      slot[1]      = 8'd0;
      digits       = 0;
      pidx         = 0;
      pval[0]      = NO_VALUE;
      pval[1]      = NO_VALUE;
      errs         = 0;
      checked      = 0;
      scrolls      = 0;
      styled_total = 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        read_data = '0;
        if (in_mon.func == FUNC_READ) begin
          if (in_mon.cell_address < ALL_CELLS) read_data = screen[in_mon.cell_address];
        end else begin
          feed_char(in_mon.char_code);
        end
        expected_results.push_back({read_data, 11'(cursor)});
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result with nothing outstanding: cell_data %h cursor %0d",
                     $realtime, out_mon.cell_data, out_mon.cursor_position);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_mon.cell_data !== want.cell_data ||
              out_mon.cursor_position !== want.cursor) begin
            errs++;
            if (errs <= 10)
              $display("%0t: result %0d: cell_data exp %h got %h, cursor exp %0d got %0d",
                       $realtime, checked, want.cell_data, out_mon.cell_data,
                       want.cursor, out_mon.cursor_position);
          end
        end
      end
    end
    pending_results <= expected_results.size();
    mismatch_count  <= errs;
    results_checked <= checked;
    scroll_count    <= scrolls;
    styled_draws    <= styled_total;
  end

endmodule

// File: sim/tb_ansi_text_screen_writer.sv
`timescale 1ns / 1ps

module tb_ansi_text_screen_writer;
  import atsw_pkg::*;

  localparam int CELL_COUNT    = DEF_COLUMNS * (DEF_TEXT_ROWS + 1);
  localparam int RANDOM_ITEMS  = 1750;
  localparam int SCROLL_CYCLES = DEF_COLUMNS * DEF_TEXT_ROWS + 3;
  localparam int CYCLE_LIMIT   = 2 * SCROLL_CYCLES
                               + (RANDOM_ITEMS + 50) * (SCROLL_CYCLES + 100) * 3;

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;
  int   items_sent = 0;
  int   sgr_sequences = 0;
  int   outside_reads = 0;
  int   cycle_count = 0;
  int   random_start;
  int   pick;
  int   mismatches;
  int   pending;
  int   checked;
  int   scrolls;
  int   styled;
  logic [8:0] text_bytes[$];

  atsw_in_if  in_ch ();
  atsw_out_if out_ch ();

  ansi_text_screen_writer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  screen_result_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatches),
    .pending_results (pending),
    .results_checked (checked),
    .scroll_count    (scrolls),
    .styled_draws    (styled)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls at random except during the calm stretch
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= 27);
  end

  function automatic logic [8:0] digit(input int n);
    return {1'b0, DIGIT_ZERO} + 9'(n);
  endfunction

  task automatic send(input logic f, input logic [8:0] c, input logic [10:0] a);
    calm = items_sent >= 800 && items_sent < 1100;
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.char_code    <= c;
    in_ch.cell_address <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (f == FUNC_READ && a >= CELL_COUNT) outside_reads++;
  endtask

  task automatic write_byte(input logic [8:0] c);
    send(~FUNC_READ, c, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int a);
    send(FUNC_READ, 9'($urandom_range(0, 256)), 11'(a));
  endtask

  task automatic flush_bytes();
    foreach (text_bytes[i]) write_byte(text_bytes[i]);
    text_bytes.delete();
  endtask

  // escape sequence with random values; a few come out malformed
  task automatic make_sgr();
    int flaw;
    int nvals;
    int v;
    flaw  = $urandom_range(0, 11);
    nvals = $urandom_range(0, 3);
    text_bytes.push_back(CHAR_ESC);
    if (flaw != 0) text_bytes.push_back(CHAR_LBRKT);
    for (int i = 0; i < nvals; i++) begin
      if (i > 0) text_bytes.push_back(CHAR_SEMI);
      case ($urandom_range(0, 5))
        0, 1:    v = 30 + $urandom_range(0, 9);
        2, 3:    v = 40 + $urandom_range(0, 9);
        4:       v = $urandom_range(0, 9);
        default: v = $urandom_range(0, 99);
      endcase
      if ($urandom_range(0, 19) == 0) begin
        // zero then slash reads back as minus one
        text_bytes.push_back(digit(0));
        text_bytes.push_back(digit(-1));
      end else begin
        if (v >= 10) text_bytes.push_back(digit(v / 10));
        text_bytes.push_back(digit(v % 10));
        if ($urandom_range(0, 9) == 0) text_bytes.push_back(digit($urandom_range(0, 9)));
      end
      if (flaw == 1) text_bytes.push_back(9'($urandom_range(0, 255)));
    end
    if (flaw != 2) text_bytes.push_back(CHAR_M);
    sgr_sequences++;
    flush_bytes();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = 1'b0;
    in_ch.char_code    = '0;
    in_ch.cell_address = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // plain text, backspace down to the origin, newline
    read_cell(0);
    write_byte(9'd65);
    write_byte(9'd255);
    write_byte(CHAR_BS);
    write_byte(CHAR_BS);
    write_byte(CHAR_LF);
    // fg and bg together, third digit and third value dropped
    text_bytes = '{CHAR_ESC, CHAR_LBRKT, digit(3), digit(1), digit(7), CHAR_SEMI,
                   digit(4), digit(4), CHAR_SEMI, digit(5), CHAR_M, 9'd88};
    flush_bytes();
    // minus one gives magenta, then a zero value ends the style
    text_bytes = '{CHAR_ESC, CHAR_LBRKT, digit(0), digit(-1), CHAR_SEMI, CHAR_M, 9'd90};
    flush_bytes();
    sgr_sequences += 2;
    read_cell(DEF_COLUMNS);
    read_cell(CELL_COUNT - 1);
    read_cell(2047);

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if ($urandom_range(0, 19) == 0) read_cell($urandom_range(CELL_COUNT, 2047));
        else read_cell($urandom_range(0, CELL_COUNT - 1));
      end else if (pick < 45) begin
        make_sgr();
      end else if (pick < 55) begin
        write_byte(CHAR_LF);
      end else if (pick < 60) begin
        write_byte(CHAR_BS);
      end else begin
        repeat ($urandom_range(1, 8)) write_byte(9'($urandom_range(0, 255)));
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d transactions sent, %0d escape sequences, %0d reads outside the display",
             items_sent, sgr_sequences, outside_reads);
    $display("%0d results checked, %0d scrolls, %0d coloured cells, %0d mismatches",
             checked, scrolls, styled, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
